>>> hdl/kdp_pkg.sv
// Shared types, codes and constants for the keyboard/display port.
`default_nettype none
package kdp_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int KEY_W               = 8;
   localparam int CHAR_W              = 7;

   localparam logic [KEY_W-1:0]  HIGH_BIT = 8'h80;
   localparam logic [CHAR_W-1:0] LOW7     = 7'h7F;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_PUSH  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      SEL_KEY_DATA = 2'd0,
      SEL_KEY_CTRL = 2'd1,
      SEL_DSP_DATA = 2'd2,
      SEL_DSP_CTRL = 2'd3
   } sel_type;

   // Request from the decode stage to the key queue.
   typedef struct packed {
      logic             push;
      logic             pop;
      logic [KEY_W-1:0] push_data;
   } queue_cmd_type;

   // Queue occupancy seen by the decode stage.
   typedef struct packed {
      logic not_empty;
      logic multi;
      logic full;
   } queue_stat_type;

   // Decoded item held between the decode register and the result register.
   typedef struct packed {
      logic [KEY_W-1:0]  read_byte;
      logic              read_from_queue;
      logic              display_valid;
      logic [CHAR_W-1:0] display_char;
      logic              key_waiting;
      logic              key_dropped;
   } stage_type;

endpackage
`default_nettype wire

>>> hdl/kdp_queue.sv
// Key FIFO: storage array, head/tail pointers, count and registered read port.
`default_nettype none
module kdp_queue #(
   parameter int QUEUE_DEPTH = kdp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire kdp_pkg::queue_cmd_type     cmd,
   output      kdp_pkg::queue_stat_type    stat,
   output      logic [kdp_pkg::KEY_W-1:0]  rd_data
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   logic [kdp_pkg::KEY_W-1:0] mem [QUEUE_DEPTH];
   logic [kdp_pkg::KEY_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]          head_ff, head_in;
   logic [IDX_W-1:0]          tail_ff, tail_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.pop) begin
         head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + ONE_CNT[IDX_W-1:0];
         count_in = count_ff - ONE_CNT;
      end
      if (cmd.push) begin
         tail_in  = (tail_ff == LAST_IDX) ? '0 : tail_ff + ONE_CNT[IDX_W-1:0];
         count_in = count_ff + ONE_CNT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Storage and read register; read data holds until the next pop.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail_ff] <= cmd.push_data;
      end
      if (cmd.pop) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign stat.not_empty = (count_ff != '0);
   assign stat.multi     = (count_ff > ONE_CNT);
   assign stat.full      = (count_ff == FULL_CNT);
   assign rd_data        = rd_data_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("key queue count above depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !stat.full)
      else $error("push into full key queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> stat.not_empty)
      else $error("pop from empty key queue");
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty key queue with unequal pointers");

endmodule
`default_nettype wire

>>> hdl/kdp_resp.sv
// Result register: merges queue read data into the decoded item and drives rsp.
`default_nettype none
module kdp_resp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       stage_valid,
   input  wire kdp_pkg::stage_type         stage,
   input  wire logic [kdp_pkg::KEY_W-1:0]  queue_data,
   output      logic                       stage_ready,
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   output      logic [23:0]                rsp_tdata,
   output      logic                       rsp_tuser
);

   logic                        valid_ff, valid_in;
   logic [kdp_pkg::KEY_W-1:0]   read_data_ff, read_data_in;
   logic                        dvalid_ff;
   logic [kdp_pkg::CHAR_W-1:0]  dchar_ff;
   logic                        waiting_ff;
   logic                        dropped_ff;
   logic                        load;

   assign stage_ready  = !valid_ff || rsp_tready;
   assign load         = stage_valid && stage_ready;
   assign valid_in     = load || (valid_ff && !rsp_tready);
   assign read_data_in = stage.read_from_queue ? queue_data : stage.read_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         read_data_ff <= read_data_in;
         dvalid_ff    <= stage.display_valid;
         dchar_ff     <= stage.display_char;
         waiting_ff   <= stage.key_waiting;
         dropped_ff   <= stage.key_dropped;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, dropped_ff, waiting_ff, dchar_ff, read_data_ff};
   assign rsp_tuser  = dvalid_ff;

   a_char_only_valid: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !dvalid_ff) |-> (dchar_ff == '0))
      else $error("display character without display_valid");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |=> (valid_ff && $stable(read_data_ff)))
      else $error("stalled result changed");
   a_drop_no_read: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && dropped_ff) |-> (read_data_ff == '0 && !dvalid_ff))
      else $error("dropped key item carries other results");

endmodule
`default_nettype wire

>>> hdl/keyboard_display_pia_top.sv
// Top level of the keyboard/display port: decode stage, key queue, result register.
//
// Usage:
//   req channel carries one item per handshake: a bus read, a bus write or a
//   key push (req_tuser selects kind and register). rsp returns exactly one
//   result item for every request item, in order.
//   An accepted item is held in the decode register, then in the result register,
//   which drives rsp. Throughput is one item per cycle: the decode register and
//   the result register each move on every cycle that the stage after them is
//   free, so back-to-back items flow without bubbles.
//   All state changes (control writes, FIFO push/pop) take effect at the edge
//   where the request is accepted; a pop also loads the FIFO read register, so
//   the popped key travels alongside its item to the result register.
//   Reset clears the control bytes and empties the FIFO; no clearing pass is
//   needed, stored keys are only read after being written.
//   When the receiver stalls, the result register holds, the decode register
//   fills, and req_tready drops after that; nothing is lost or repeated.
//   A push to a full FIFO is discarded and reported with key_dropped.
`default_nettype none
module keyboard_display_pia_top #(
   parameter int QUEUE_DEPTH = kdp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,  // [7:0] write_data, [15:8] key_char
   input  wire logic [3:0]  req_tuser,  // [1:0] operation, [3:2] reg_select
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] read_data, [14:8] display_char, [15] key_waiting, [16] key_dropped
   output      logic [23:0] rsp_tdata,
   output      logic        rsp_tuser   // [0] display_valid
);

   kdp_pkg::op_type          op;
   kdp_pkg::sel_type         sel;
   logic [kdp_pkg::KEY_W-1:0] wdata;
   logic [kdp_pkg::KEY_W-1:0] kchar;
   logic                      accept;

   kdp_pkg::queue_cmd_type    qcmd;
   kdp_pkg::queue_stat_type   qstat;
   logic [kdp_pkg::KEY_W-1:0] qdata;

   logic [kdp_pkg::KEY_W-1:0] key_ctrl_ff, key_ctrl_in;
   logic [kdp_pkg::KEY_W-1:0] dsp_ctrl_ff, dsp_ctrl_in;

   kdp_pkg::stage_type        stage_ff, stage_in;
   logic                      stage_valid_ff, stage_valid_in;
   logic                      stage_ready;

   // Unpack the request item.
   assign op    = kdp_pkg::op_type'(req_tuser[1:0]);
   assign sel   = kdp_pkg::sel_type'(req_tuser[3:2]);
   assign wdata = req_tdata[7:0];
   assign kchar = req_tdata[15:8];

   // Take a new item whenever the decode register is empty or draining.
   assign req_tready = !stage_valid_ff || stage_ready;
   assign accept     = req_tvalid && req_tready;

   // Decode: work out the register/FIFO effects and the result fields.
   always_comb begin
      qcmd        = '0;
      stage_in    = '0;
      key_ctrl_in = key_ctrl_ff;
      dsp_ctrl_in = dsp_ctrl_ff;
      qcmd.push_data = kchar | kdp_pkg::HIGH_BIT;
      unique case (op)
         kdp_pkg::OP_READ: begin
            unique case (sel)
               kdp_pkg::SEL_KEY_DATA: begin
                  // Pop the oldest key; an empty FIFO reads as zero.
                  qcmd.pop                 = qstat.not_empty;
                  stage_in.read_from_queue = qstat.not_empty;
               end
               kdp_pkg::SEL_KEY_CTRL: begin
                  stage_in.read_byte = key_ctrl_ff |
                                       (qstat.not_empty ? kdp_pkg::HIGH_BIT : '0);
               end
               kdp_pkg::SEL_DSP_DATA, kdp_pkg::SEL_DSP_CTRL: begin
                  // Display is always ready: return its control byte as is.
                  stage_in.read_byte = dsp_ctrl_ff;
               end
            endcase
         end
         kdp_pkg::OP_WRITE: begin
            unique case (sel)
               kdp_pkg::SEL_KEY_DATA: ;  // drop writes to key data
               kdp_pkg::SEL_KEY_CTRL: key_ctrl_in = wdata;
               kdp_pkg::SEL_DSP_DATA: begin
                  // Emit the character only when bit 7 is clear.
                  if ((wdata & kdp_pkg::HIGH_BIT) == '0) begin
                     stage_in.display_valid = 1'b1;
                     stage_in.display_char  = wdata[kdp_pkg::CHAR_W-1:0] & kdp_pkg::LOW7;
                  end
               end
               kdp_pkg::SEL_DSP_CTRL: dsp_ctrl_in = wdata;
            endcase
         end
         kdp_pkg::OP_PUSH: begin
            if (qstat.full) begin
               stage_in.key_dropped = 1'b1;
            end else begin
               qcmd.push = 1'b1;
            end
         end
         default: ;  // unused operation code: no effect
      endcase

      // FIFO occupancy after this item.
      priority if (qcmd.push) begin
         stage_in.key_waiting = 1'b1;
      end else if (qcmd.pop) begin
         stage_in.key_waiting = qstat.multi;
      end else begin
         stage_in.key_waiting = qstat.not_empty;
      end

      // Only an accepted item may change state.
      if (!accept) begin
         qcmd.push   = 1'b0;
         qcmd.pop    = 1'b0;
         key_ctrl_in = key_ctrl_ff;
         dsp_ctrl_in = dsp_ctrl_ff;
      end
   end

   assign stage_valid_in = accept || (stage_valid_ff && !stage_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         key_ctrl_ff    <= '0;
         dsp_ctrl_ff    <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         key_ctrl_ff    <= key_ctrl_in;
         dsp_ctrl_ff    <= dsp_ctrl_in;
      end
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   kdp_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .cmd     (qcmd),
      .stat    (qstat),
      .rd_data (qdata)
   );

   kdp_resp u_resp (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid_ff),
      .stage       (stage_ff),
      .queue_data  (qdata),
      .stage_ready (stage_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   a_state_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(key_ctrl_ff) && $stable(dsp_ctrl_ff)))
      else $error("control byte changed without an item");
   a_queue_ops_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(qcmd.push && qcmd.pop))
      else $error("push and pop in the same cycle");
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !stage_ready) |=> (stage_valid_ff && $stable(stage_ff)))
      else $error("stalled decode register changed");

endmodule
`default_nettype wire

>>> test/keyboard_display_pia_top_test.sv
// Self-checking stream testbench for the keyboard/display port top level.
`timescale 1ns / 100ps
`default_nettype none
module keyboard_display_pia_top_test;

   localparam int KEY_DEPTH     = kdp_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 1130;   // random items after the table
   localparam int STALL_LIMIT   = 2000;   // cycles with no handshake at all
   localparam int HOLDOFF_START = 300;    // item count that starts the long stall
   localparam int HOLDOFF_LEN   = 250;
   localparam int QUIET_FIRST   = 500;    // window of items with no idling
   localparam int QUIET_LAST    = 700;
   localparam int DRAIN_CYCLES  = 4;      // decode and result registers plus margin

   // The operation field has one code the block does not define.
   localparam logic [1:0] OP_NONE = 2'd3;

   // One result item, holding each field that the port returns.
   typedef struct packed {
      logic [7:0] read_data;
      logic       display_valid;
      logic [6:0] display_char;
      logic       key_waiting;
      logic       key_dropped;
   } port_result_type;

   // One directed row: stimulus, then the typed-in result where fixed is set.
   typedef struct packed {
      logic [1:0] op;
      logic [1:0] sel;
      logic [7:0] wdata;
      logic [7:0] kchar;
      logic       fixed;
      logic [7:0] read_data;
      logic       display_valid;
      logic [6:0] display_char;
      logic       key_waiting;
      logic       key_dropped;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 25;

   directed_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      // empty port after reset: every register reads zero
      '{kdp_pkg::OP_READ, kdp_pkg::SEL_KEY_DATA, 8'h00, 8'h00,
        1'b1, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0},
      '{kdp_pkg::OP_READ, kdp_pkg::SEL_KEY_CTRL, 8'h00, 8'h00,
        1'b1, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0},
      '{kdp_pkg::OP_READ, kdp_pkg::SEL_DSP_DATA, 8'h00, 8'h00,
        1'b1, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0},
      '{kdp_pkg::OP_READ, kdp_pkg::SEL_DSP_CTRL, 8'h00, 8'h00,
        1'b1, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0},
      // unused operation code does nothing
      '{OP_NONE, kdp_pkg::SEL_KEY_DATA, 8'hFF, 8'hFF,
        1'b1, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0},
      // key control holds a full byte; bit 7 reads back as written
      '{kdp_pkg::OP_WRITE, kdp_pkg::SEL_KEY_CTRL, 8'hFF, 8'h00,
        1'b1, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0},
      '{kdp_pkg::OP_READ, kdp_pkg::SEL_KEY_CTRL, 8'h00, 8'h00,
        1'b1, 8'hFF, 1'b0, 7'h00, 1'b0, 1'b0},
      // write to key data is dropped
      '{kdp_pkg::OP_WRITE, kdp_pkg::SEL_KEY_DATA, 8'hAA, 8'h00,
        1'b1, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0},
      // display writes: bit 7 clear emits, bit 7 set is ignored
      '{kdp_pkg::OP_WRITE, kdp_pkg::SEL_DSP_DATA, 8'h7F, 8'h00,
        1'b1, 8'h00, 1'b1, 7'h7F, 1'b0, 1'b0},
      '{kdp_pkg::OP_WRITE, kdp_pkg::SEL_DSP_DATA, 8'h80, 8'h00,
        1'b1, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0},
      '{kdp_pkg::OP_WRITE, kdp_pkg::SEL_DSP_DATA, 8'hFF, 8'h00,
        1'b1, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0},
      '{kdp_pkg::OP_WRITE, kdp_pkg::SEL_DSP_DATA, 8'h00, 8'h00,
        1'b1, 8'h00, 1'b1, 7'h00, 1'b0, 1'b0},
      // display data reads return display control, bit 7 untouched
      '{kdp_pkg::OP_WRITE, kdp_pkg::SEL_DSP_CTRL, 8'hFF, 8'h00,
        1'b1, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0},
      '{kdp_pkg::OP_READ, kdp_pkg::SEL_DSP_DATA, 8'h00, 8'h00,
        1'b1, 8'hFF, 1'b0, 7'h00, 1'b0, 1'b0},
      '{kdp_pkg::OP_READ, kdp_pkg::SEL_DSP_CTRL, 8'h00, 8'h00,
        1'b1, 8'hFF, 1'b0, 7'h00, 1'b0, 1'b0},
      '{kdp_pkg::OP_WRITE, kdp_pkg::SEL_KEY_CTRL, 8'h00, 8'h00,
        1'b1, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0},
      // key pushes at both extremes, stored with bit 7 forced
      '{kdp_pkg::OP_PUSH, kdp_pkg::SEL_KEY_DATA, 8'h00, 8'h00,
        1'b1, 8'h00, 1'b0, 7'h00, 1'b1, 1'b0},
      '{kdp_pkg::OP_PUSH, kdp_pkg::SEL_DSP_CTRL, 8'hFF, 8'hFF,
        1'b1, 8'h00, 1'b0, 7'h00, 1'b1, 1'b0},
      '{kdp_pkg::OP_READ, kdp_pkg::SEL_KEY_CTRL, 8'h00, 8'h00,
        1'b1, 8'h80, 1'b0, 7'h00, 1'b1, 1'b0},
      '{OP_NONE, kdp_pkg::SEL_KEY_CTRL, 8'h00, 8'h00,
        1'b1, 8'h00, 1'b0, 7'h00, 1'b1, 1'b0},
      '{kdp_pkg::OP_READ, kdp_pkg::SEL_KEY_DATA, 8'h00, 8'h00,
        1'b1, 8'h80, 1'b0, 7'h00, 1'b1, 1'b0},
      '{kdp_pkg::OP_READ, kdp_pkg::SEL_KEY_DATA, 8'h00, 8'h00,
        1'b1, 8'hFF, 1'b0, 7'h00, 1'b0, 1'b0},
      // pop from an empty queue reads zero
      '{kdp_pkg::OP_READ, kdp_pkg::SEL_KEY_DATA, 8'h00, 8'h00,
        1'b1, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0},
      '{kdp_pkg::OP_WRITE, kdp_pkg::SEL_DSP_CTRL, 8'h5A, 8'h00,
        1'b0, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0},
      '{kdp_pkg::OP_READ, kdp_pkg::SEL_DSP_DATA, 8'h00, 8'h00,
        1'b0, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [7:0] write_data, [15:8] key_char
   logic [3:0]  req_tuser  = '0;   // [1:0] operation, [3:2] reg_select
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [7:0] read_data, [14:8] display_char, [15] key_waiting, [16] key_dropped
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;         // [0] display_valid

   // Predictor state: shadow copy of the key queue and both control bytes.
   logic [7:0]      key_fifo [$];
   logic [7:0]      key_ctrl_shadow = '0;
   logic [7:0]      dsp_ctrl_shadow = '0;
   port_result_type expected_results [$];

   int items_sent   = 0;
   int error_count  = 0;
   int idle_cycles  = 0;
   int hold_cycles  = 0;
   bit holdoff_done = 1'b0;

   keyboard_display_pia_top #(
      .QUEUE_DEPTH(KEY_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Start in reset, then release it for good.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Work out the result of one accepted item and advance the shadow state.
   function automatic port_result_type compute_port_result(
      input logic [1:0] op,
      input logic [1:0] sel,
      input logic [7:0] wdata,
      input logic [7:0] kchar
   );
      port_result_type r;
      r = '0;
      case (op)
         kdp_pkg::OP_READ: begin
            case (sel)
               kdp_pkg::SEL_KEY_DATA: begin
                  if (key_fifo.size() != 0) r.read_data = key_fifo.pop_front();
               end
               kdp_pkg::SEL_KEY_CTRL: begin
                  r.read_data = key_ctrl_shadow |
                                (key_fifo.size() != 0 ? kdp_pkg::HIGH_BIT : 8'h00);
               end
               default: r.read_data = dsp_ctrl_shadow;
            endcase
         end
         kdp_pkg::OP_WRITE: begin
            case (sel)
               kdp_pkg::SEL_KEY_CTRL: key_ctrl_shadow = wdata;
               kdp_pkg::SEL_DSP_DATA: begin
                  if (!wdata[7]) begin
                     r.display_valid = 1'b1;
                     r.display_char  = wdata[6:0];
                  end
               end
               kdp_pkg::SEL_DSP_CTRL: dsp_ctrl_shadow = wdata;
               default: ;
            endcase
         end
         kdp_pkg::OP_PUSH: begin
            if (key_fifo.size() >= KEY_DEPTH) r.key_dropped = 1'b1;
            else key_fifo.push_back(kchar | kdp_pkg::HIGH_BIT);
         end
         default: ;
      endcase
      r.key_waiting = (key_fifo.size() != 0);
      return r;
   endfunction

   function automatic bit idling_allowed();
      return items_sent < QUIET_FIRST || items_sent >= QUIET_LAST;
   endfunction

   function automatic void check_field(
      input string      name,
      input logic [7:0] exp_value,
      input logic [7:0] act_value
   );
      if (exp_value !== act_value) begin
         $display("%0t: %s mismatch, expected %02h, actual %02h",
                  $time, name, exp_value, act_value);
         error_count++;
      end
   endfunction

   // Offer one item, wait for its handshake, then record what it must produce.
   task automatic send_item(
      input logic [1:0]      op,
      input logic [1:0]      sel,
      input logic [7:0]      wdata,
      input logic [7:0]      kchar,
      input bit              fixed,
      input port_result_type fixed_result
   );
      port_result_type predicted;
      // idle the sender for a random number of cycles
      while (idling_allowed() && $urandom_range(0, 99) < 36) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {kchar, wdata};
      req_tuser  <= {sel, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = compute_port_result(op, sel, wdata, kchar);
      expected_results.push_back(fixed ? fixed_result : predicted);
      items_sent++;
   endtask

   // Random part: bursts of pushes and pops fill and drain the key queue
   // (overrunning it now and then), with register traffic and noise between.
   task automatic run_random_traffic();
      int         counted;
      int         mode;
      int         burst;
      logic [1:0] op;
      logic [1:0] sel;
      logic [7:0] wdata;
      logic [7:0] kchar;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         mode  = $urandom_range(0, 99);
         burst = $urandom_range(1, 24);
         for (int n = 0; n < burst; n++) begin
            wdata = 8'($urandom);
            kchar = 8'($urandom);
            if (mode < 30) begin
               op  = kdp_pkg::OP_PUSH;
               sel = 2'($urandom);
            end else if (mode < 60) begin
               op  = kdp_pkg::OP_READ;
               sel = ($urandom_range(0, 9) == 0) ? kdp_pkg::SEL_KEY_CTRL
                                                 : kdp_pkg::SEL_KEY_DATA;
            end else if (mode < 90) begin
               op  = ($urandom_range(0, 1) == 0) ? kdp_pkg::OP_READ : kdp_pkg::OP_WRITE;
               sel = 2'($urandom_range(1, 3));
            end else begin
               op  = 2'($urandom);
               sel = 2'($urandom);
            end
            send_item(op, sel, wdata, kchar, 1'b0, '0);
            counted++;
         end
      end
   endtask

   // Sender: walk the directed table, then the random traffic, then drain.
   initial begin
      port_result_type typed;
      wait (!reset);
      @(posedge clock);
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         typed.read_data     = directed_rows[i].read_data;
         typed.display_valid = directed_rows[i].display_valid;
         typed.display_char  = directed_rows[i].display_char;
         typed.key_waiting   = directed_rows[i].key_waiting;
         typed.key_dropped   = directed_rows[i].key_dropped;
         send_item(directed_rows[i].op, directed_rows[i].sel, directed_rows[i].wdata,
                   directed_rows[i].kchar, directed_rows[i].fixed, typed);
      end
      run_random_traffic();
      req_tvalid <= 1'b0;
      // wait for every expected item, then DRAIN_CYCLES more to catch extras
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("keyboard_display_pia_top_test passed");
      end else begin
         $display("keyboard_display_pia_top_test failed");
      end
      $finish;
   end

   // Receiver: random stalls, one long hold-off that backs up the input side,
   // and no stalls at all inside the quiet window.
   initial begin
      forever begin
         @(posedge clock);
         if (!holdoff_done && items_sent >= HOLDOFF_START) begin
            hold_cycles  = HOLDOFF_LEN;
            holdoff_done = 1'b1;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(idling_allowed() && $urandom_range(0, 99) < 36);
         end
      end
   end

   // Compare each accepted result item with the oldest expectation.
   always @(posedge clock) begin
      port_result_type wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result item, actual %06h / %b",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            wanted = expected_results.pop_front();
            check_field("read_data", wanted.read_data, rsp_tdata[7:0]);
            check_field("display_valid", {7'd0, wanted.display_valid}, {7'd0, rsp_tuser});
            check_field("display_char", {1'b0, wanted.display_char}, {1'b0, rsp_tdata[14:8]});
            check_field("key_waiting", {7'd0, wanted.key_waiting}, {7'd0, rsp_tdata[15]});
            check_field("key_dropped", {7'd0, wanted.key_dropped}, {7'd0, rsp_tdata[16]});
         end
      end
   end

   // Watchdog: drop the run if no handshake happens for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("keyboard_display_pia_top_test failed");
         $finish;
      end
   end

endmodule
`default_nettype wire
